### rtl/core/piecewise_linear_colormap_top_macros.svh
// Assertion helpers used by the colormap controller
`ifndef PIECEWISE_LINEAR_COLORMAP_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_COLORMAP_TOP_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define PLC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/plc_pkg.sv
package plc_pkg;

    localparam int MAX_STOPS_DEF = 16;
    localparam int KEY_W         = 16;
    localparam int COLOR_W       = 8;
    localparam int OPCODE_W      = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    // source of the result register
    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_DROP  = 2'd1,
        RES_COLOR = 2'd2,
        RES_BLEND = 2'd3
    } res_sel_t;

    typedef struct packed {
        logic [OPCODE_W-1:0]      opcode;
        logic signed [KEY_W-1:0]  key;
        logic [COLOR_W-1:0]       red_in;
        logic [COLOR_W-1:0]       green_in;
        logic [COLOR_W-1:0]       blue_in;
    } in_item_t;

    typedef struct packed {
        logic                status;
        logic [COLOR_W-1:0]  red_out;
        logic [COLOR_W-1:0]  green_out;
        logic [COLOR_W-1:0]  blue_out;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic     load;       // capture input item
        logic     clear;      // empty the table
        logic     ins_start;  // index to top of table
        logic     ins_read;   // read entry below the index
        logic     ins_move;   // move read entry up, step index down
        logic     ins_write;  // write the new stop at the index
        logic     lk_start;   // index to bottom of table
        logic     lk_read;    // read entry at index, step index up
        logic     div_start;
        logic     div_step;
        logic     res_load;
        res_sel_t res_sel;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic idx_zero;
        logic idx_first;   // last read was entry zero
        logic at_end;      // every entry has been read
        logic rd_lt_q;
        logic rd_gt_q;
        logic div_done;
    } ctrl_sts_t;

endpackage

### rtl/core/plc_ctrl.sv
`include "piecewise_linear_colormap_top_macros.svh"

module plc_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [plc_pkg::OPCODE_W-1:0]  opcode,
    output logic                          out_valid,
    input  logic                          out_stall,
    output plc_pkg::ctrl_cmd_t            cmd,
    input  plc_pkg::ctrl_sts_t            sts
);

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_IREAD  = 8'b0000_0010,
        ST_ICMP   = 8'b0000_0100,
        ST_IWRITE = 8'b0000_1000,
        ST_LREAD  = 8'b0001_0000,
        ST_LCMP   = 8'b0010_0000,
        ST_DIV    = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    plc_pkg::res_sel_t sel_reg, sel_next;
    logic out_valid_reg, out_valid_next;

    logic take;
    logic out_free;
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign take = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    cmd.load   = 1'b1;
                    sel_next   = plc_pkg::RES_ZERO;
                    state_next = ST_OUT;
                    case (opcode)
                        plc_pkg::OP_INSERT:
                        begin
                            if (sts.full)
                                sel_next = plc_pkg::RES_DROP;
                            else
                            begin
                                cmd.ins_start = 1'b1;
                                state_next    = ST_IREAD;
                            end
                        end
                        plc_pkg::OP_CLEAR:
                            cmd.clear = 1'b1;
                        plc_pkg::OP_LOOKUP:
                        begin
                            if (!sts.empty)
                            begin
                                cmd.lk_start = 1'b1;
                                state_next   = ST_LREAD;
                            end
                        end
                        default:
                            sel_next = plc_pkg::RES_ZERO;
                    endcase
                end
            end
            // insert walks down from the top, moving stops not below the key
            ST_IREAD:
            begin
                if (sts.idx_zero)
                    state_next = ST_IWRITE;
                else
                begin
                    cmd.ins_read = 1'b1;
                    state_next   = ST_ICMP;
                end
            end
            ST_ICMP:
            begin
                if (sts.rd_lt_q)
                    state_next = ST_IWRITE;
                else
                begin
                    cmd.ins_move = 1'b1;
                    state_next   = ST_IREAD;
                end
            end
            ST_IWRITE:
            begin
                cmd.ins_write = 1'b1;
                state_next    = ST_OUT;
            end
            // lookup stops at the first key above the query or at the last stop
            ST_LREAD:
            begin
                cmd.lk_read = 1'b1;
                state_next  = ST_LCMP;
            end
            ST_LCMP:
            begin
                if (sts.rd_gt_q)
                begin
                    if (sts.idx_first)
                    begin
                        sel_next   = plc_pkg::RES_COLOR;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
                else if (sts.at_end)
                begin
                    sel_next   = plc_pkg::RES_COLOR;
                    state_next = ST_OUT;
                end
                else
                    state_next = ST_LREAD;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    sel_next   = plc_pkg::RES_BLEND;
                    state_next = ST_OUT;
                end
                else
                    cmd.div_step = 1'b1;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_sel    = sel_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= plc_pkg::RES_ZERO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `PLC_ASSERT_IMP(a_onehot, clk, rst_n, 1'b1, $onehot(state_reg), "state not one-hot")
    `PLC_ASSERT_NEXT(a_take_busy, clk, rst_n, take, state_reg != ST_IDLE, "accept did not start work")
    `PLC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_reg && out_stall, out_valid_reg, "stalled result dropped")
    `PLC_ASSERT_IMP(a_no_load, clk, rst_n, out_valid_reg && out_stall, !cmd.res_load, "result overwritten while stalled")

endmodule

### rtl/core/plc_dp.sv
module plc_dp #(
    parameter int MAX_STOPS = plc_pkg::MAX_STOPS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  plc_pkg::in_item_t    in_item,
    output plc_pkg::out_item_t   out_item,
    input  plc_pkg::ctrl_cmd_t   cmd,
    output plc_pkg::ctrl_sts_t   sts
);

    localparam int IW        = $clog2(MAX_STOPS);
    localparam int CW        = $clog2(MAX_STOPS + 1);
    localparam int KW        = plc_pkg::KEY_W;
    localparam int NW        = KW + 8;                 // 8-bit color times segment width
    localparam int DIV_STEPS = plc_pkg::COLOR_W;
    localparam int DCW       = $clog2(DIV_STEPS + 1);

    logic signed [KW-1:0] keys_mem [MAX_STOPS];
    logic [23:0] colors_mem [MAX_STOPS];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] idx_reg;
    logic signed [KW-1:0] q_reg;
    logic [23:0] new_col_reg;
    logic signed [KW-1:0] rd_key_reg;
    logic [23:0] rd_col_reg;
    logic signed [KW-1:0] prev_key_reg;
    logic [23:0] prev_col_reg;
    plc_pkg::out_item_t res_reg;

    // divider lanes, one per channel
    logic [KW-1:0]  rem_reg [3];
    logic [7:0]     lo_reg [3];
    logic [7:0]     quo_reg [3];
    logic [KW-1:0]  den_reg;
    logic [DCW-1:0] dcnt_reg;

    logic [CW-1:0] idx_dec;
    logic [IW-1:0] wr_addr, rd_addr;
    assign idx_dec = idx_reg - CW'(1);
    assign wr_addr = idx_reg[IW-1:0];
    assign rd_addr = cmd.lk_read ? idx_reg[IW-1:0] : idx_dec[IW-1:0];

    assign sts.empty     = (count_reg == '0);
    assign sts.full      = (count_reg == CW'(MAX_STOPS));
    assign sts.idx_zero  = (idx_reg == '0);
    assign sts.idx_first = (idx_reg == CW'(1));
    assign sts.at_end    = (idx_reg == count_reg);
    assign sts.rd_lt_q   = (rd_key_reg < q_reg);
    assign sts.rd_gt_q   = (rd_key_reg > q_reg);
    assign sts.div_done  = (dcnt_reg == '0);

    always_ff @(posedge clk)
    begin
        if (cmd.ins_move)
        begin
            keys_mem[wr_addr]   <= rd_key_reg;
            colors_mem[wr_addr] <= rd_col_reg;
        end
        else if (cmd.ins_write)
        begin
            keys_mem[wr_addr]   <= q_reg;
            colors_mem[wr_addr] <= new_col_reg;
        end
        if (cmd.ins_read || cmd.lk_read)
        begin
            rd_key_reg <= keys_mem[rd_addr];
            rd_col_reg <= colors_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            q_reg       <= in_item.key;
            new_col_reg <= {in_item.red_in, in_item.green_in, in_item.blue_in};
        end
        // lookup keeps the entry below the one just read
        if (cmd.lk_read)
        begin
            prev_key_reg <= rd_key_reg;
            prev_col_reg <= rd_col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            if (cmd.clear)
                count_reg <= '0;
            else if (cmd.ins_write)
                count_reg <= count_reg + CW'(1);
            if (cmd.ins_start)
                idx_reg <= count_reg;
            else if (cmd.lk_start)
                idx_reg <= '0;
            else if (cmd.ins_move)
                idx_reg <= idx_dec;
            else if (cmd.lk_read)
                idx_reg <= idx_reg + CW'(1);
        end
    end

    // segment between prev (below or at query) and rd (above query)
    logic [KW-1:0] width_w, right_w, left_w;
    assign width_w = $unsigned(rd_key_reg) - $unsigned(prev_key_reg);
    assign right_w = $unsigned(q_reg) - $unsigned(prev_key_reg);
    assign left_w  = $unsigned(rd_key_reg) - $unsigned(q_reg);

    logic [NW-1:0] num_w [3];
    always_comb
    begin
        for (int l = 0; l < 3; l++)
            num_w[l] = NW'(prev_col_reg[23-8*l -: 8]) * NW'(left_w)
                     + NW'(rd_col_reg[23-8*l -: 8]) * NW'(right_w);
    end

    // quotient fits 8 bits, so the upper numerator bits start below the divisor
    logic [KW:0] trial_w [3];
    logic        sub_w [3];
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            trial_w[l] = {rem_reg[l], lo_reg[l][7]};
            sub_w[l]   = (trial_w[l] >= {1'b0, den_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            den_reg <= width_w;
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[l] <= num_w[l][NW-1:8];
                lo_reg[l]  <= num_w[l][7:0];
            end
        end
        else if (cmd.div_step)
        begin
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[l] <= sub_w[l] ? KW'(trial_w[l] - {1'b0, den_reg}) :
                                         trial_w[l][KW-1:0];
                lo_reg[l]  <= {lo_reg[l][6:0], 1'b0};
                quo_reg[l] <= {quo_reg[l][6:0], sub_w[l]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dcnt_reg <= '0;
        else if (cmd.div_start)
            dcnt_reg <= DCW'(DIV_STEPS);
        else if (cmd.div_step)
            dcnt_reg <= dcnt_reg - DCW'(1);
    end

    assign out_item = res_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            case (cmd.res_sel)
                plc_pkg::RES_DROP:
                    res_reg <= '{status: 1'b1, red_out: '0, green_out: '0, blue_out: '0};
                plc_pkg::RES_COLOR:
                    res_reg <= '{status: 1'b0, red_out: rd_col_reg[23:16],
                                 green_out: rd_col_reg[15:8], blue_out: rd_col_reg[7:0]};
                plc_pkg::RES_BLEND:
                    res_reg <= '{status: 1'b0, red_out: quo_reg[0],
                                 green_out: quo_reg[1], blue_out: quo_reg[2]};
                default:
                    res_reg <= '{status: 1'b0, red_out: '0, green_out: '0, blue_out: '0};
            endcase
        end
    end

endmodule

### rtl/core/piecewise_linear_colormap_top.sv
// Piecewise linear color ramp lookup.
// Input channel in_valid/in_stall carries one in_item per transfer:
// opcode insert, clear or lookup, a signed key and a stop color.
// Output channel out_valid/out_stall returns one result per item:
// status (1 = insert dropped, table full) and an RGB color.
// One item is worked at a time; in_stall stays high until the result is
// loaded into the output register. Clear, unused opcode, dropped insert
// and lookup on an empty table go straight to the result. Insert walks
// down from the top of the table, moving up each stop not below the key.
// Lookup scans up for the first stop above the query; below the first
// stop or at or past the last it returns that stop's color, else an
// 8-step divider blends the channels of the two stops around the query.
// A stalled result holds the output register; the next item may run but
// waits for that register before it finishes.
// Reset empties the table and the output channel; stop storage is not
// cleared.
module piecewise_linear_colormap_top #(
    parameter int MAX_STOPS = plc_pkg::MAX_STOPS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  plc_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_stall,
    output plc_pkg::out_item_t  out_item
);

    plc_pkg::ctrl_cmd_t cmd;
    plc_pkg::ctrl_sts_t sts;

    plc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (in_item.opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    plc_dp #(
        .MAX_STOPS (MAX_STOPS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .out_item (out_item),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
